// ===== hdl/wmsd_pkg.sv =====
package wmsd_pkg;

    // largest matrix side the store is sized for
    localparam int MAX_SIZE = 64;

    localparam int DEPTH   = MAX_SIZE * MAX_SIZE;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int IDX_W   = $clog2(MAX_SIZE);
    localparam int SIZE_W  = $clog2(MAX_SIZE + 1);

    // register fields
    localparam int CFG_SIZE_W = 7;
    localparam int CFG_HALF_W = 5;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HALF = 1'd1;

    localparam logic [CFG_SIZE_W-1:0] RST_MATRIX_SIZE = 7'd64;
    localparam logic [CFG_HALF_W-1:0] RST_WINDOW_HALF = 5'd1;

    // position arithmetic must hold a position plus the half-width
    localparam int PW = ((SIZE_W > CFG_HALF_W) ? SIZE_W : CFG_HALF_W) + 1;

    // datapath widths
    localparam int VAL_W  = 16;
    localparam int SQ_W   = 32;
    localparam int CNT_W  = 13;
    localparam int SUM_W  = 44;
    localparam int DIST_W = 22;
    localparam int REM_W  = DIST_W + 3;
    localparam int SQRT_CNT_W = $clog2(DIST_W);

    // stream widths
    localparam int S_TDATA_W = 2 * VAL_W;
    localparam int M_TDATA_W = ((DIST_W + 7) / 8) * 8;

    // result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_WIDE = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_FLUSH,
        ST_SQRT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic scan_start;
        logic scan_step;
        logic sqrt_start;
        logic sqrt_step;
        logic emit_ok;
        logic emit_err;
    } cmd_t;

    typedef struct packed {
        logic complete;
        logic too_wide;
        logic scan_last;
        logic pipe_busy;
        logic sqrt_last;
        logic out_full;
    } stat_t;

endpackage

// ===== hdl/windowed_min_sq_diff_distance.sv =====
// loading: items load one per cycle while the block is in its load state, held off only when
//   a completing item meets a waiting result; after the last item of a matrix the window scan,
//   pipeline flush, root and emit states run before the result is valid; a too-wide window
//   answers directly with an error result. No item is taken from scan start until emit.
// reset: async active low; control, count and config (size 64, half-width 1) reset,
//   the difference store is undefined until loaded
module windowed_min_sq_diff_distance (
    input  logic                              clk,
    input  logic                              rst_n,

    // configuration write port
    input  logic                              cfg_we,
    input  logic [wmsd_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [wmsd_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    // input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [wmsd_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // first_value, second_value

    // result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [wmsd_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // distance, zero fill
    output logic                              m_axis_tuser   // status
);

    wmsd_pkg::cmd_t                   cmd;
    wmsd_pkg::stat_t                  st;
    logic [wmsd_pkg::DIST_W-1:0]      distance;

    // controller sequences load, window scan, pipeline flush, root, emit
    wmsd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .st            (st),
        .cmd           (cmd)
    );

    // datapath holds the store, scan counters, min/sum pipeline and root unit
    wmsd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .first_value   (s_axis_tdata[wmsd_pkg::VAL_W-1:0]),
        .second_value  (s_axis_tdata[2*wmsd_pkg::VAL_W-1:wmsd_pkg::VAL_W]),
        .cmd           (cmd),
        .st            (st),
        .m_axis_tready (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .distance      (distance),
        .status        (m_axis_tuser)
    );

    assign m_axis_tdata = wmsd_pkg::M_TDATA_W'(distance);

    // a completing item is never taken while a result is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && s_axis_tready) |-> !st.complete)
        else $error("completing item accepted over a pending result");

    // no item enters while the scan runs
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> !s_axis_tready)
        else $error("item accepted during scan");

    // the root starts only after the last minimum reached the sum
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sqrt_start |-> !st.pipe_busy)
        else $error("root started with scan pipeline busy");

    // error results carry zero distance
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == wmsd_pkg::STATUS_WIDE)) |-> (distance == '0))
        else $error("error result with nonzero distance");

endmodule

// ===== hdl/wmsd_ram.sv =====
module wmsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/wmsd_ctrl.sv =====
module wmsd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  wmsd_pkg::stat_t st,
    output wmsd_pkg::cmd_t  cmd
);

    wmsd_pkg::state_t state_reg;
    wmsd_pkg::state_t state_next;
    logic             accept;

    // a completing item is held off while the previous result is unclaimed
    assign s_axis_tready = (state_reg == wmsd_pkg::ST_LOAD) &&
                           (!st.out_full || !st.complete);
    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wmsd_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wmsd_pkg::ST_LOAD:
            begin
                if (accept && st.complete && !st.too_wide)
                begin
                    state_next = wmsd_pkg::ST_SCAN;
                end
            end
            wmsd_pkg::ST_SCAN:
            begin
                if (st.scan_last)
                begin
                    state_next = wmsd_pkg::ST_FLUSH;
                end
            end
            wmsd_pkg::ST_FLUSH:
            begin
                if (!st.pipe_busy)
                begin
                    state_next = wmsd_pkg::ST_SQRT;
                end
            end
            wmsd_pkg::ST_SQRT:
            begin
                if (st.sqrt_last)
                begin
                    state_next = wmsd_pkg::ST_EMIT;
                end
            end
            wmsd_pkg::ST_EMIT:
            begin
                state_next = wmsd_pkg::ST_LOAD;
            end
            default:
            begin
                state_next = wmsd_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            wmsd_pkg::ST_LOAD:
            begin
                cmd.load_item  = accept;
                cmd.emit_err   = accept && st.complete && st.too_wide;
                cmd.scan_start = accept && st.complete && !st.too_wide;
            end
            wmsd_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            wmsd_pkg::ST_FLUSH:
            begin
                cmd.sqrt_start = !st.pipe_busy;
            end
            wmsd_pkg::ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
            end
            wmsd_pkg::ST_EMIT:
            begin
                cmd.emit_ok = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/wmsd_dp.sv =====
module wmsd_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wmsd_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [wmsd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [wmsd_pkg::VAL_W-1:0]          first_value,
    input  logic [wmsd_pkg::VAL_W-1:0]          second_value,
    input  wmsd_pkg::cmd_t                      cmd,
    output wmsd_pkg::stat_t                     st,
    input  logic                                m_axis_tready,
    output logic                                out_valid,
    output logic [wmsd_pkg::DIST_W-1:0]         distance,
    output logic                                status
);

    localparam int PW     = wmsd_pkg::PW;
    localparam int IDX_W  = wmsd_pkg::IDX_W;
    localparam int SIZE_W = wmsd_pkg::SIZE_W;
    localparam int ADDR_W = wmsd_pkg::ADDR_W;
    localparam int CNT_W  = wmsd_pkg::CNT_W;
    localparam int SUM_W  = wmsd_pkg::SUM_W;
    localparam int SQ_W   = wmsd_pkg::SQ_W;
    localparam int DIST_W = wmsd_pkg::DIST_W;
    localparam int REM_W  = wmsd_pkg::REM_W;
    localparam int TOT_W  = 2 * SIZE_W;
    localparam int NCMP_W = ((SIZE_W > wmsd_pkg::CFG_SIZE_W) ? SIZE_W : wmsd_pkg::CFG_SIZE_W) + 1;
    localparam int TCMP_W = TOT_W + CNT_W;
    localparam int WCMP_W = ((CNT_W > ADDR_W) ? CNT_W : ADDR_W) + 1;

    // configuration
    logic [wmsd_pkg::CFG_SIZE_W-1:0] size_reg;
    logic [wmsd_pkg::CFG_HALF_W-1:0] half_reg;
    logic [SIZE_W-1:0]               n_eff;
    logic [PW-1:0]                   n_w;
    logic [PW-1:0]                   h_w;
    logic [PW-1:0]                   nm1_w;

    // loading
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_inc;
    logic [TOT_W-1:0]          total;
    logic [wmsd_pkg::VAL_W-1:0] diff;
    logic [SQ_W-1:0]           sq;
    logic                      ram_we;
    logic [SQ_W-1:0]           rdata;

    // window scan
    logic [IDX_W-1:0]          r_reg, c_reg, rr_reg, cc_reg;
    logic [IDX_W-1:0]          r_nx, c_nx;
    logic [IDX_W+SIZE_W-1:0]   row_base;
    logic [ADDR_W-1:0]         raddr;
    logic                      row_at_hi, col_at_hi, win_first, win_last, pos_last;

    // min and sum pipeline
    logic                      t1_v_reg, t1_first_reg, t1_last_reg;
    logic [SQ_W-1:0]           cur_min_reg, pick;
    logic                      win_v_reg;
    logic [SQ_W-1:0]           win_min_reg;
    logic [SUM_W-1:0]          sum_reg;

    // square root, two radicand bits per step
    logic [SUM_W-1:0]                   rad_reg;
    logic [REM_W-1:0]                   rem_reg, cand, test;
    logic [DIST_W-1:0]                  root_reg;
    logic [wmsd_pkg::SQRT_CNT_W-1:0]    sq_cnt_reg;
    logic                               ge;

    logic                      out_valid_reg;
    logic [DIST_W-1:0]         dist_reg;
    logic                      status_reg;

    function automatic logic [IDX_W-1:0] lo_bound(input logic [IDX_W-1:0] x,
                                                  input logic [PW-1:0] h);
        logic [PW-1:0] xw;
        xw = PW'(x);
        lo_bound = (xw > h) ? IDX_W'(xw - h) : '0;
    endfunction

    function automatic logic [IDX_W-1:0] hi_bound(input logic [IDX_W-1:0] x,
                                                  input logic [PW-1:0] h,
                                                  input logic [PW-1:0] nm1);
        logic [PW-1:0] s;
        s = PW'(x) + h;
        hi_bound = (s > nm1) ? IDX_W'(nm1) : IDX_W'(s);
    endfunction

    // size clamped to 1..MAX_SIZE
    always_comb
    begin
        if (size_reg == '0)
        begin
            n_eff = SIZE_W'(1);
        end
        else if (NCMP_W'(size_reg) > NCMP_W'(wmsd_pkg::MAX_SIZE))
        begin
            n_eff = SIZE_W'(wmsd_pkg::MAX_SIZE);
        end
        else
        begin
            n_eff = SIZE_W'(size_reg);
        end
    end

    assign n_w   = PW'(n_eff);
    assign h_w   = PW'(half_reg);
    assign nm1_w = n_w - PW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= wmsd_pkg::RST_MATRIX_SIZE;
            half_reg <= wmsd_pkg::RST_WINDOW_HALF;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                wmsd_pkg::REG_MATRIX_SIZE: size_reg <= cfg_wdata[wmsd_pkg::CFG_SIZE_W-1:0];
                wmsd_pkg::REG_WINDOW_HALF: half_reg <= cfg_wdata[wmsd_pkg::CFG_HALF_W-1:0];
                default: ;
            endcase
        end
    end

    // loading
    assign count_inc = count_reg + CNT_W'(1);
    assign total     = TOT_W'(n_eff) * TOT_W'(n_eff);
    assign diff      = (first_value > second_value) ? (first_value - second_value)
                                                    : (second_value - first_value);
    assign sq        = SQ_W'(diff) * SQ_W'(diff);
    assign ram_we    = cmd.load_item && (WCMP_W'(count_reg) < WCMP_W'(wmsd_pkg::DEPTH));

    assign st.complete  = TCMP_W'(count_inc) >= TCMP_W'(total);
    assign st.too_wide  = ((PW'(half_reg) << 1) + PW'(1)) > n_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.load_item)
        begin
            count_reg <= st.complete ? '0 : count_inc;
        end
    end

    wmsd_ram #(
        .WIDTH (SQ_W),
        .DEPTH (wmsd_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(count_reg)),
        .wdata (sq),
        .raddr (raddr),
        .rdata (rdata)
    );

    // window scan over clipped bounds
    assign row_base  = (IDX_W + SIZE_W)'(rr_reg) * (IDX_W + SIZE_W)'(n_eff);
    assign raddr     = ADDR_W'(row_base) + ADDR_W'(cc_reg);
    assign row_at_hi = (rr_reg == hi_bound(r_reg, h_w, nm1_w));
    assign col_at_hi = (cc_reg == hi_bound(c_reg, h_w, nm1_w));
    assign win_first = (rr_reg == lo_bound(r_reg, h_w)) && (cc_reg == lo_bound(c_reg, h_w));
    assign win_last  = row_at_hi && col_at_hi;
    assign pos_last  = (PW'(r_reg) == nm1_w) && (PW'(c_reg) == nm1_w);
    assign st.scan_last = cmd.scan_step && win_last && pos_last;

    always_comb
    begin
        if (PW'(c_reg) == nm1_w)
        begin
            c_nx = '0;
            r_nx = r_reg + IDX_W'(1);
        end
        else
        begin
            c_nx = c_reg + IDX_W'(1);
            r_nx = r_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg  <= '0;
            c_reg  <= '0;
            rr_reg <= '0;
            cc_reg <= '0;
        end
        else if (cmd.scan_start)
        begin
            r_reg  <= '0;
            c_reg  <= '0;
            rr_reg <= '0;
            cc_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            if (!col_at_hi)
            begin
                cc_reg <= cc_reg + IDX_W'(1);
            end
            else if (!row_at_hi)
            begin
                rr_reg <= rr_reg + IDX_W'(1);
                cc_reg <= lo_bound(c_reg, h_w);
            end
            else
            begin
                r_reg  <= r_nx;
                c_reg  <= c_nx;
                rr_reg <= lo_bound(r_nx, h_w);
                cc_reg <= lo_bound(c_nx, h_w);
            end
        end
    end

    // running minimum, then accumulate
    assign pick = t1_first_reg ? rdata : ((rdata < cur_min_reg) ? rdata : cur_min_reg);
    assign st.pipe_busy = t1_v_reg || win_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_v_reg  <= 1'b0;
            win_v_reg <= 1'b0;
        end
        else
        begin
            t1_v_reg  <= cmd.scan_step;
            win_v_reg <= t1_v_reg && t1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_first_reg <= win_first;
        t1_last_reg  <= win_last;
        if (t1_v_reg)
        begin
            cur_min_reg <= pick;
        end
        if (t1_v_reg && t1_last_reg)
        begin
            win_min_reg <= pick;
        end
        if (cmd.scan_start)
        begin
            sum_reg <= '0;
        end
        else if (win_v_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(win_min_reg);
        end
    end

    // restoring square root
    assign cand = {rem_reg[REM_W-3:0], rad_reg[SUM_W-1 -: 2]};
    assign test = (REM_W'(root_reg) << 2) | REM_W'(1);
    assign ge   = (cand >= test);
    assign st.sqrt_last = (sq_cnt_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            rad_reg    <= sum_reg;
            rem_reg    <= '0;
            root_reg   <= '0;
            sq_cnt_reg <= wmsd_pkg::SQRT_CNT_W'(DIST_W - 1);
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg    <= rad_reg << 2;
            rem_reg    <= ge ? (cand - test) : cand;
            root_reg   <= {root_reg[DIST_W-2:0], ge};
            sq_cnt_reg <= sq_cnt_reg - wmsd_pkg::SQRT_CNT_W'(1);
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_ok || cmd.emit_err)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_ok)
        begin
            dist_reg   <= root_reg;
            status_reg <= wmsd_pkg::STATUS_OK;
        end
        else if (cmd.emit_err)
        begin
            dist_reg   <= '0;
            status_reg <= wmsd_pkg::STATUS_WIDE;
        end
    end

    assign st.out_full = out_valid_reg;
    assign out_valid   = out_valid_reg;
    assign distance    = dist_reg;
    assign status      = status_reg;

endmodule

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // run limits
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int HOLD_OFF       = 8;     // load pipeline settles before a register write
    localparam int TAIL_CYCLES    = 64;    // stray results would show up here
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_PAIRS   = 1050;

    // how the values of one matrix are drawn
    typedef enum int {
        FILL_RANDOM,
        FILL_CLOSE,
        FILL_EXTREME,
        FILL_OPPOSITE
    } fill_t;

    // one expected result item
    typedef struct packed {
        logic [wmsd_pkg::DIST_W-1:0] distance;
        logic                        status;
    } verdict_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // configuration port, idle from time zero
    logic                            cfg_we    = 1'b0;
    logic [wmsd_pkg::CFG_IDX_W-1:0]  cfg_addr  = wmsd_pkg::REG_MATRIX_SIZE;
    logic [wmsd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // input stream
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [wmsd_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;  // first_value, second_value

    // result stream
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [wmsd_pkg::M_TDATA_W-1:0] m_axis_tdata;        // distance, zero fill
    logic                           m_axis_tuser;        // status

    // stall percentages, changed between test phases
    int tx_idle_pct = 16;
    int rx_idle_pct = 45;

    // bookkeeping
    int failures    = 0;
    int pairs_sent  = 0;
    int cycle_count = 0;

    // expected distances, oldest first
    verdict_t pending_distances[$];

    // shadow of the block: squared differences, pair count and registers
    logic [wmsd_pkg::SQ_W-1:0]       diff_sq [0:wmsd_pkg::DEPTH-1];
    logic [wmsd_pkg::CNT_W-1:0]      pairs_loaded = '0;
    logic [wmsd_pkg::CFG_SIZE_W-1:0] size_reg     = wmsd_pkg::RST_MATRIX_SIZE;
    logic [wmsd_pkg::CFG_HALF_W-1:0] half_reg     = wmsd_pkg::RST_WINDOW_HALF;

    windowed_min_sq_diff_distance DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver backpressure, redrawn every cycle
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result checker: every accepted item against the oldest expectation
    always @(posedge clk)
    begin : check_distance
        verdict_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_distances.size() == 0)
            begin
                failures = failures + 1;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected item: distance %0d status %0d",
                             m_axis_tdata[wmsd_pkg::DIST_W-1:0], m_axis_tuser);
            end
            else
            begin
                want = pending_distances.pop_front();
                if (m_axis_tdata[wmsd_pkg::DIST_W-1:0] !== want.distance ||
                    m_axis_tuser !== want.status)
                begin
                    failures = failures + 1;
                    if (failures <= REPORT_LIMIT)
                        $display("mismatch: distance %0d status %0d, expected %0d status %0d",
                                 m_axis_tdata[wmsd_pkg::DIST_W-1:0], m_axis_tuser,
                                 want.distance, want.status);
                end
            end
        end
    end

    // floor of the square root, built one bit at a time from the top
    function automatic logic [wmsd_pkg::DIST_W-1:0] floor_root(
        input logic [wmsd_pkg::SUM_W-1:0] v);
        logic [wmsd_pkg::DIST_W-1:0] root;
        logic [wmsd_pkg::DIST_W-1:0] trial;
        logic [63:0]                 wide_trial;
        root = '0;
        for (int i = wmsd_pkg::DIST_W - 1; i >= 0; i--)
        begin
            trial      = root | (22'd1 << i);
            wide_trial = {42'd0, trial};
            if (wide_trial * wide_trial <= {20'd0, v})
                root = trial;
        end
        return root;
    endfunction

    // store one pair; on the last pair of a matrix, queue the expected distance
    function automatic void absorb_pair(input logic [wmsd_pkg::VAL_W-1:0] first,
                                        input logic [wmsd_pkg::VAL_W-1:0] second);
        logic [wmsd_pkg::VAL_W-1:0] gap;
        logic [wmsd_pkg::SQ_W-1:0]  best;
        logic [63:0]                total;
        verdict_t                   outcome;
        int                         n;
        int                         h;
        gap = (first > second) ? first - second : second - first;
        if (pairs_loaded < wmsd_pkg::DEPTH)
            diff_sq[pairs_loaded] = {16'd0, gap} * {16'd0, gap};
        pairs_loaded = pairs_loaded + 1'b1;

        // out-of-range sizes clamp to 1 and MAX_SIZE
        n = (size_reg == 0) ? 1
            : ((size_reg > wmsd_pkg::MAX_SIZE) ? wmsd_pkg::MAX_SIZE : int'(size_reg));
        h = int'(half_reg);
        if (int'(pairs_loaded) < n * n)
            return;
        pairs_loaded = '0;

        if (2 * h + 1 > n)
        begin
            // window wider than the matrix: error status, zero distance
            outcome.distance = '0;
            outcome.status   = wmsd_pkg::STATUS_WIDE;
        end
        else
        begin
            total = '0;
            for (int r = 0; r < n; r++)
                for (int c = 0; c < n; c++)
                begin
                    best = '1;
                    // window clipped at the matrix edges
                    for (int rr = ((r - h < 0) ? 0 : r - h); rr <= r + h && rr < n; rr++)
                        for (int cc = ((c - h < 0) ? 0 : c - h); cc <= c + h && cc < n; cc++)
                            if (diff_sq[rr * n + cc] < best)
                                best = diff_sq[rr * n + cc];
                    total = total + {32'd0, best};
                end
            outcome.distance = floor_root(total[wmsd_pkg::SUM_W-1:0]);
            outcome.status   = wmsd_pkg::STATUS_OK;
        end
        pending_distances.push_back(outcome);
    endfunction

    // draw one pair, packed as on the bus: first value low, second value high
    function automatic logic [wmsd_pkg::S_TDATA_W-1:0] pick_pair(input fill_t how);
        logic [wmsd_pkg::VAL_W-1:0] a;
        logic [wmsd_pkg::VAL_W-1:0] b;
        a = 16'($urandom_range(16'hFFFF));
        b = 16'($urandom_range(16'hFFFF));
        case (how)
            FILL_CLOSE:
                b = a + 16'($urandom_range(16)) - 16'd8;
            FILL_EXTREME:
            begin
                a = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                b = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            end
            FILL_OPPOSITE:
            begin
                a = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                b = ~a;
            end
            default:
                ;
        endcase
        return {b, a};
    endfunction

    // send one item; tvalid stays high into the next item unless the sender idles
    task automatic send_pair(input logic [wmsd_pkg::S_TDATA_W-1:0] pair);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pair;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pairs_sent = pairs_sent + 1;
        absorb_pair(pair[wmsd_pkg::VAL_W-1:0],
                    pair[wmsd_pkg::S_TDATA_W-1:wmsd_pkg::VAL_W]);
    endtask

    // keep sending until the current matrix completes
    task automatic send_matrix(input fill_t how);
        do
            send_pair(pick_pair(how));
        while (pairs_loaded != 0);
    endtask

    // sender pauses until all results are in, then the size register alone is written
    task automatic program_size(input logic [wmsd_pkg::CFG_SIZE_W-1:0] size);
        s_axis_tvalid <= 1'b0;
        while (pending_distances.size() != 0)
            @(posedge clk);
        repeat (HOLD_OFF) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= wmsd_pkg::REG_MATRIX_SIZE;
        cfg_wdata <= size;
        @(posedge clk);
        cfg_we    <= 1'b0;
        size_reg = size;
    endtask

    // sender pauses until all results are in, then both registers are written
    task automatic program_window(input logic [wmsd_pkg::CFG_SIZE_W-1:0] size,
                                  input logic [wmsd_pkg::CFG_HALF_W-1:0] half);
        s_axis_tvalid <= 1'b0;
        while (pending_distances.size() != 0)
            @(posedge clk);
        repeat (HOLD_OFF) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= wmsd_pkg::REG_MATRIX_SIZE;
        cfg_wdata <= size;
        @(posedge clk);
        cfg_addr  <= wmsd_pkg::REG_WINDOW_HALF;
        cfg_wdata <= {{(wmsd_pkg::CFG_DATA_W - wmsd_pkg::CFG_HALF_W){1'b0}}, half};
        @(posedge clk);
        cfg_we    <= 1'b0;
        size_reg = size;
        half_reg = half;
    endtask

    // reset size holds off completion; shrinking it completes under the reset half-width
    task automatic test_reset_defaults();
        repeat (20) send_pair(pick_pair(FILL_OPPOSITE));
        program_size(7'd4);
        send_matrix(FILL_OPPOSITE);
    endtask

    // one-by-one matrices, including a size of zero
    task automatic test_single_cell();
        program_window(7'd1, 5'd0);
        send_pair({16'h0000, 16'hFFFF});
        send_pair({16'hFFFF, 16'h0000});
        send_pair({16'h4D2A, 16'h4D2A});
        program_window(7'd0, 5'd0);
        send_pair({16'h7FFF, 16'h8000});
    endtask

    // window exactly as wide as the matrix, then one step too wide, then far too wide
    task automatic test_window_limits();
        program_window(7'd3, 5'd1);
        send_matrix(FILL_RANDOM);
        program_window(7'd2, 5'd1);
        send_matrix(FILL_RANDOM);
        program_window(7'd1, 5'd31);
        send_matrix(FILL_EXTREME);
    endtask

    // size written while a matrix is partly loaded, shrinking below the count and growing
    task automatic test_size_change_midway();
        program_window(7'd4, 5'd0);
        repeat (5) send_pair(pick_pair(FILL_RANDOM));
        program_window(7'd2, 5'd0);
        send_matrix(FILL_RANDOM);
        program_window(7'd2, 5'd0);
        repeat (2) send_pair(pick_pair(FILL_CLOSE));
        program_window(7'd3, 5'd1);
        send_matrix(FILL_CLOSE);
    endtask

    // largest register value clamps to MAX_SIZE, so a short run never completes
    task automatic test_size_clamp();
        program_window(7'd127, 5'd0);
        repeat (10) send_pair(pick_pair(FILL_RANDOM));
        program_window(7'd3, 5'd0);
        send_matrix(FILL_RANDOM);
    endtask

    // random small matrices, random windows, some size changes mid-matrix
    task automatic test_random_traffic(input int quota);
        logic [wmsd_pkg::CFG_SIZE_W-1:0] size;
        logic [wmsd_pkg::CFG_HALF_W-1:0] half;
        fill_t                           how;
        int                              start;
        int                              eff;
        int                              pick;
        int                              cut;
        start = pairs_sent;
        while (pairs_sent - start < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                size = 7'd0;
            else if (pick < 80)
                size = 7'($urandom_range(6, 1));
            else
                size = 7'($urandom_range(12, 7));
            eff = (size == 0) ? 1 : int'(size);

            // mostly a window that fits, sometimes any reach at all
            if ($urandom_range(99) < 80)
                half = 5'($urandom_range((eff - 1) / 2));
            else
                half = 5'($urandom_range(31));

            program_window(size, half);
            how = fill_t'($urandom_range(3));

            if ($urandom_range(9) == 0 && eff > 1)
            begin
                cut = $urandom_range(eff * eff - 1, 1);
                repeat (cut) send_pair(pick_pair(how));
                program_window(7'($urandom_range(6, 1)), half);
            end
            send_matrix(how);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, sender idles lightly, receiver heavily
        test_reset_defaults();
        test_single_cell();
        test_window_limits();
        test_size_change_midway();
        test_size_clamp();

        // random part in three stall phases
        test_random_traffic(RANDOM_PAIRS / 3);
        tx_idle_pct = 45;
        rx_idle_pct = 16;
        test_random_traffic(RANDOM_PAIRS / 3);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(RANDOM_PAIRS - 2 * (RANDOM_PAIRS / 3));

        // drain and give stray results a chance to appear
        s_axis_tvalid <= 1'b0;
        while (pending_distances.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
